// ----- rtl/core/sqtm_pkg.sv -----
// ----------------------------------------------------------------------------
// sqtm_pkg: shared constants of the squarified treemap layout
// Field widths, register indexes and the request/response payload layout.
// ----------------------------------------------------------------------------
package sqtm_pkg;

   localparam int unsigned CoordW   = 32;
   localparam int unsigned AreaW    = 40;
   localparam int unsigned SumW     = 48;
   localparam int unsigned IndexW   = 16;
   localparam int unsigned MaxRow   = 16;
   localparam int unsigned NumW     = 64;   // dividend width: 48 + 16 bits

   localparam int unsigned ReqDataW = 56;   // area_value, area_index
   localparam int unsigned RspDataW = 144;  // x, y, w, h, index

   localparam logic [1:0] RegX = 2'd0;
   localparam logic [1:0] RegY = 2'd1;
   localparam logic [1:0] RegW = 2'd2;
   localparam logic [1:0] RegH = 2'd3;

   localparam logic [CoordW-1:0] Sat32 = '1;

endpackage

// ----- rtl/core/sqtm_divider.sv -----
// ----------------------------------------------------------------------------
// sqtm_divider: bit-serial restoring divider with 32-bit saturation
// One quotient bit per cycle over a 64-bit dividend; zero divisor saturates.
// ----------------------------------------------------------------------------
module sqtm_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [sqtm_pkg::NumW-1:0]       num,
   input  logic [sqtm_pkg::NumW-1:0]       den,
   output logic                            done,
   output logic [sqtm_pkg::CoordW-1:0]     quot
);

   localparam int unsigned NW = sqtm_pkg::NumW;

   logic [NW-1:0]   num_ff, num_in;
   logic [NW-1:0]   den_ff, den_in;
   logic [NW:0]     rem_ff, rem_in;
   logic [NW-1:0]   q_ff, q_in;
   logic [6:0]      cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [NW:0]     trial;

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[NW-1:0], num_ff[NW-1]};
      if (start) begin
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         q_in    = '0;
         cnt_in  = 7'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract when it fits
         num_in = {num_ff[NW-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            q_in   = {q_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in   = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign quot = (den_ff == '0 || q_ff[NW-1:32] != '0) ? sqtm_pkg::Sat32 : q_ff[31:0];

endmodule

// ----- rtl/core/squarified_treemap_layout.sv -----
// ----------------------------------------------------------------------------
// squarified_treemap_layout: streaming squarified treemap in fixed point
// Areas arrive one per item; rows of rectangles are emitted as they close.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  req     | in        | tdata: area_value[39:0], area_index[55:40]; tlast: is_last
//  rsp     | out       | tdata: rect_x, rect_y, rect_w, rect_h, rect_index; tlast: run_end
//  csr     | in        | write enable, index 0..3, 32-bit data
//
//  Every division runs on one shared bit-serial divider. A decision to grow
//  the row takes ten divisions; laying out a row takes one division for the
//  thickness plus one per rectangle.
//  Reset clears the row and the free region to zero; row entries are not cleared.
//  One item is worked on at a time; req_tready is low until its results leave.
//  A waiting result holds in the output register while rsp_tready is low.
// ----------------------------------------------------------------------------
module squarified_treemap_layout #(
   parameter int unsigned MAX_ROW = sqtm_pkg::MaxRow
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [sqtm_pkg::ReqDataW-1:0]     req_tdata,  // area_value, area_index
   input  logic                              req_tlast,  // is_last
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [sqtm_pkg::RspDataW-1:0]     rsp_tdata,  // rect_x,rect_y,rect_w,rect_h,rect_index
   output logic                              rsp_tlast,  // run_end
   input  logic                              csr_we,
   input  logic [1:0]                        csr_index,
   input  logic [sqtm_pkg::CoordW-1:0]       csr_wdata
);

   localparam int unsigned CW = sqtm_pkg::CoordW;
   localparam int unsigned AW = sqtm_pkg::AreaW;
   localparam int unsigned SW = sqtm_pkg::SumW;
   localparam int unsigned IW = sqtm_pkg::IndexW;
   localparam int unsigned NW = sqtm_pkg::NumW;
   localparam int unsigned PW = $clog2(MAX_ROW);
   localparam int unsigned LW = $clog2(MAX_ROW + 1);

   typedef enum logic [4:0] {
      S_IDLE, S_DECIDE,
      S_R_T, S_R_LMAX, S_R_LMIN, S_R_A1, S_R_A2,
      S_CMP, S_LAY_T, S_LAY_RD, S_LAY_LEN, S_LAY_OUT, S_LAY_END,
      S_APPEND, S_LAST, S_DONE
   } state_type;

   // -------------------------------------------------------------------------
   // state
   // -------------------------------------------------------------------------
   state_type       state_ff;
   logic [CW-1:0]   reg_x_ff, reg_y_ff, reg_w_ff, reg_h_ff;
   logic [CW-1:0]   free_x_ff, free_y_ff, free_w_ff, free_h_ff;
   logic [LW-1:0]   len_ff;
   logic [SW-1:0]   sum_ff;
   logic [AW-1:0]   max_ff, min_ff;
   logic [AW+IW-1:0] row_mem [MAX_ROW];
   logic [AW+IW-1:0] rd_ff;

   logic [AW-1:0]   a_ff;
   logic [IW-1:0]   idx_ff;
   logic            last_ff;
   logic            pass_ff;      // 0: current row ratio, 1: grown row ratio
   logic [CW-1:0]   side_ff, t_ff, lmax_ff, lmin_ff, a1_ff, cur_ff;
   logic            vert_ff;
   logic [CW-1:0]   cx_ff, cy_ff;
   logic [PW-1:0]   pos_ff;
   logic            lay_last_ff;  // laying out the flush on the last item

   logic            ov_ff;

   logic            dv_start;
   logic [NW-1:0]   dv_num, dv_den;
   logic            dv_done;
   logic [CW-1:0]   dv_q;

   // result register: one rectangle held until the next one is known, so
   // run_end can be set on the last of an item
   logic            hold_ff;
   logic [4*CW+IW-1:0] hold_data_ff;
   logic [4*CW+IW-1:0] rsp_data_ff;
   logic            rsp_last_ff;

   sqtm_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (dv_start),
      .num   (dv_num),
      .den   (dv_den),
      .done  (dv_done),
      .quot  (dv_q)
   );

   wire [SW-1:0] nsum  = sum_ff + SW'(a_ff);
   wire [AW-1:0] nmax  = (a_ff > max_ff) ? a_ff : max_ff;
   wire [AW-1:0] nmin  = (a_ff < min_ff) ? a_ff : min_ff;
   wire [SW-1:0] psum  = pass_ff ? nsum : sum_ff;
   wire [AW-1:0] pmax  = pass_ff ? nmax : max_ff;
   wire [AW-1:0] pmin  = pass_ff ? nmin : min_ff;
   wire          out_free = !rsp_tvalid || rsp_tready;
   wire          rsp_load = hold_ff && out_free &&
                            (state_ff == S_LAY_OUT || state_ff == S_DONE);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      dv_start = 1'b0;
      dv_num   = '0;
      dv_den   = '0;
      unique case (state_ff)
         S_DECIDE: begin
            dv_start = (len_ff != LW'(MAX_ROW)) && (len_ff != '0)
                       && (side_ff != '0 || 1'b1);
            dv_num   = {psum, 16'd0};
            dv_den   = NW'(side_ff);
         end
         S_R_T:    begin dv_num = {8'd0, pmax, 16'd0}; dv_den = NW'(dv_q); end
         S_R_LMAX: begin dv_num = {8'd0, pmin, 16'd0}; dv_den = NW'(t_ff); end
         S_R_LMIN: begin dv_num = {16'd0, lmax_ff, 16'd0}; dv_den = NW'(t_ff); end
         S_R_A1:   begin dv_num = {16'd0, t_ff, 16'd0}; dv_den = NW'(lmin_ff); end
         S_LAY_RD: begin dv_num = {8'd0, rd_ff[AW+IW-1:IW], 16'd0}; dv_den = NW'(t_ff); end
         default:  ;
      endcase
      dv_start = dv_start | ((state_ff == S_R_T || state_ff == S_R_LMAX ||
                  state_ff == S_R_LMIN || state_ff == S_R_A1) && dv_done)
                  | (state_ff == S_LAY_RD);
      if (state_ff == S_LAY_T && !dv_done && !ov_ff) begin
         dv_start = 1'b1;
         dv_num   = {sum_ff, 16'd0};
         dv_den   = NW'(vert_ff ? free_h_ff : free_w_ff);
      end
   end

   // -------------------------------------------------------------------------
   // sequencer
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         reg_x_ff    <= '0; reg_y_ff <= '0; reg_w_ff <= '0; reg_h_ff <= '0;
         free_x_ff   <= '0; free_y_ff <= '0; free_w_ff <= '0; free_h_ff <= '0;
         len_ff      <= '0;
         sum_ff      <= '0;
         max_ff      <= '0;
         min_ff      <= '0;
         hold_ff     <= 1'b0;
         rsp_tvalid  <= 1'b0;
         ov_ff       <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready && !rsp_load) rsp_tvalid <= 1'b0;
         if (csr_we) begin
            unique case (csr_index)
               sqtm_pkg::RegX: begin reg_x_ff <= csr_wdata; free_x_ff <= csr_wdata; end
               sqtm_pkg::RegY: begin reg_y_ff <= csr_wdata; free_y_ff <= csr_wdata; end
               sqtm_pkg::RegW: begin reg_w_ff <= csr_wdata; free_w_ff <= csr_wdata; end
               sqtm_pkg::RegH: begin reg_h_ff <= csr_wdata; free_h_ff <= csr_wdata; end
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  a_ff     <= req_tdata[AW-1:0];
                  idx_ff   <= req_tdata[AW+IW-1:AW];
                  last_ff  <= req_tlast;
                  pass_ff  <= 1'b0;
                  side_ff  <= (free_w_ff < free_h_ff) ? free_w_ff : free_h_ff;
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               lay_last_ff <= 1'b0;
               ov_ff       <= 1'b0;
               vert_ff     <= free_w_ff >= free_h_ff;
               if (len_ff == LW'(MAX_ROW)) state_ff <= S_LAY_T;
               else if (len_ff == '0)      state_ff <= S_APPEND;
               else                         state_ff <= S_R_T;
            end
            S_R_T:    if (dv_done) begin t_ff <= dv_q;    state_ff <= S_R_LMAX; end
            S_R_LMAX: if (dv_done) begin lmax_ff <= dv_q; state_ff <= S_R_LMIN; end
            S_R_LMIN: if (dv_done) begin lmin_ff <= dv_q; state_ff <= S_R_A1; end
            S_R_A1:   if (dv_done) begin a1_ff <= dv_q;   state_ff <= S_R_A2; end
            S_R_A2: begin
               if (dv_done) begin
                  // zero short side means ratio 0
                  if (!pass_ff) begin
                     cur_ff   <= (side_ff == '0) ? '0 : ((a1_ff > dv_q) ? a1_ff : dv_q);
                     pass_ff  <= 1'b1;
                     state_ff <= S_DECIDE;
                  end else begin
                     a1_ff    <= (side_ff == '0) ? '0 : ((a1_ff > dv_q) ? a1_ff : dv_q);
                     state_ff <= S_CMP;
                  end
               end
            end
            S_CMP: state_ff <= (cur_ff < a1_ff) ? S_LAY_T : S_APPEND;
            S_LAY_T: begin
               ov_ff <= 1'b1;
               if (dv_done) begin
                  t_ff     <= dv_q;
                  cx_ff    <= free_x_ff;
                  cy_ff    <= free_y_ff;
                  pos_ff   <= '0;
                  ov_ff    <= 1'b0;
                  state_ff <= S_LAY_RD;
                  rd_ff    <= row_mem[0];
               end
            end
            S_LAY_RD:  state_ff <= S_LAY_LEN;
            S_LAY_LEN: if (dv_done) state_ff <= S_LAY_OUT;
            S_LAY_OUT: begin
               if (out_free) begin
                  if (hold_ff) begin
                     rsp_tvalid  <= 1'b1;
                     rsp_data_ff <= hold_data_ff;
                     rsp_last_ff <= 1'b0;
                  end
                  hold_ff      <= 1'b1;
                  hold_data_ff <= {rd_ff[IW-1:0], vert_ff ? dv_q : t_ff,
                                   vert_ff ? t_ff : dv_q, cy_ff, cx_ff};
                  if (vert_ff) cy_ff <= cy_ff + dv_q;
                  else         cx_ff <= cx_ff + dv_q;
                  if (LW'(pos_ff) + LW'(1) == len_ff) begin
                     state_ff <= S_LAY_END;
                  end else begin
                     pos_ff   <= pos_ff + PW'(1);
                     rd_ff    <= row_mem[pos_ff + PW'(1)];
                     state_ff <= S_LAY_RD;
                  end
               end
            end
            S_LAY_END: begin
               if (vert_ff) begin
                  free_x_ff <= free_x_ff + t_ff;
                  free_w_ff <= (free_w_ff > t_ff) ? free_w_ff - t_ff : '0;
               end else begin
                  free_y_ff <= free_y_ff + t_ff;
                  free_h_ff <= (free_h_ff > t_ff) ? free_h_ff - t_ff : '0;
               end
               len_ff <= '0; sum_ff <= '0; max_ff <= '0; min_ff <= '0;
               state_ff <= lay_last_ff ? S_DONE : S_APPEND;
            end
            S_APPEND: begin
               row_mem[len_ff[PW-1:0]] <= {a_ff, idx_ff};
               max_ff   <= (len_ff == '0) ? a_ff : nmax;
               min_ff   <= (len_ff == '0) ? a_ff : nmin;
               sum_ff   <= nsum;
               len_ff   <= len_ff + LW'(1);
               state_ff <= last_ff ? S_LAST : S_DONE;
            end
            S_LAST: begin
               lay_last_ff <= 1'b1;
               vert_ff     <= free_w_ff >= free_h_ff;
               state_ff    <= S_LAY_T;
            end
            S_DONE: begin
               // flush the held rectangle marked as the end of this item
               if (hold_ff) begin
                  if (out_free) begin
                     rsp_tvalid  <= 1'b1;
                     rsp_data_ff <= hold_data_ff;
                     rsp_last_ff <= 1'b1;
                     hold_ff     <= 1'b0;
                  end
               end else if (!rsp_tvalid || rsp_tready) begin
                  if (last_ff) begin
                     len_ff <= '0; sum_ff <= '0; max_ff <= '0; min_ff <= '0;
                     free_x_ff <= reg_x_ff; free_y_ff <= reg_y_ff;
                     free_w_ff <= reg_w_ff; free_h_ff <= reg_h_ff;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // checks
   // -------------------------------------------------------------------------
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LW'(MAX_ROW)) else $error("row length past store depth");
   a_busy_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready) else $error("ready while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped while stalled");
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !hold_ff) else $error("held result at idle");

endmodule
